// ----- hdl/integer_set_store_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the integer set store.
// Each macro expects signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SET_STORE_ASSERT_SVH
`define INTEGER_SET_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Types and constants shared by the integer set store modules.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_READ     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
		logic [ADDR_W-1:0]         index;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic                      rejected_full;
		logic signed [DATA_W-1:0]  entry_value;
		logic                      index_valid;
		logic [CNT_W-1:0]          count;
	} rsp_t;

	typedef struct packed {
		logic                      we;
		logic [ADDR_W-1:0]         waddr;
		logic signed [DATA_W-1:0]  wdata;
		logic [ADDR_W-1:0]         raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_APPEND,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_READ_RD,
		ST_READ_CMP
	} state_t;

endpackage

// ----- hdl/iss_req_if.sv -----
// ----------------------------------------------------------------------------
// iss_req_if
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface iss_req_if;
	import iss_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/iss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// iss_rsp_if
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface iss_rsp_if;
	import iss_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/iss_ram.sv -----
// ----------------------------------------------------------------------------
// iss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module iss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/iss_ctrl.sv -----
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer that walks the entry RAM with one shared equality compare to
// add, remove, look up and read entries, one request at a time.
// ----------------------------------------------------------------------------
`include "integer_set_store_assert.svh"

module iss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  iss_pkg::req_t     req,
	output logic              res_valid,
	input  logic              res_ready,
	output iss_pkg::rsp_t     res,
	output iss_pkg::ram_req_t ram_req,
	input  logic [iss_pkg::DATA_W-1:0] ram_rdata
);
	import iss_pkg::*;

	state_t state_q, state_d;

	kind_t                    kind_q;
	logic signed [DATA_W-1:0] value_q;
	logic [ADDR_W-1:0]        index_q;
	logic [ADDR_W-1:0]        ptr_q;
	logic [CNT_W-1:0]         count_q;
	logic                     hit_q;
	logic                     full_q;
	logic signed [DATA_W-1:0] ev_q;
	logic                     valid_q;
	logic                     done_q;

	logic eq;
	logic more;
	logic shift_more;
	logic idx_ok;
	logic is_full;
	logic accept;

	// Shared compare unit: entry against the request value, and the scan bound.
	assign eq      = (ram_rdata == value_q);
	assign more    = (({1'b0, ptr_q} + CNT_W'(1)) < count_q);
	// During the shift the count already holds the new value, and every slot
	// below it from the match upward takes the entry above it.
	assign shift_more = ({1'b0, ptr_q} < count_q);
	assign idx_ok  = ({1'b0, req.index} < count_q);
	assign is_full = (count_q >= CNT_W'(CAPACITY));
	assign accept  = req_valid && req_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && !done_q) begin
					if (req.kind == KIND_READ) begin
						state_d = idx_ok ? ST_READ_RD : ST_IDLE;
					end else if (count_q == '0) begin
						state_d = (req.kind == KIND_ADD) ? ST_APPEND : ST_IDLE;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (eq) begin
					state_d = (kind_q == KIND_REMOVE) ? ST_SHIFT_RD : ST_IDLE;
				end else if (more) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = (kind_q == KIND_ADD) ? ST_APPEND : ST_IDLE;
				end
			end
			ST_APPEND:   state_d = ST_IDLE;
			ST_SHIFT_RD: state_d = shift_more ? ST_SHIFT_WR : ST_IDLE;
			ST_SHIFT_WR: state_d = ST_SHIFT_RD;
			ST_READ_RD:  state_d = ST_READ_CMP;
			ST_READ_CMP: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and RAM port.
	always_comb begin
		req_ready     = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = ptr_q;
		ram_req.wdata = value_q;
		ram_req.raddr = ptr_q;
		unique case (state_q)
			ST_IDLE:     req_ready = !done_q;
			ST_SCAN_RD:  ram_req.raddr = ptr_q;
			ST_SCAN_CMP: ram_req.raddr = ptr_q;
			ST_APPEND: begin
				ram_req.we    = !is_full;
				ram_req.waddr = count_q[ADDR_W-1:0];
			end
			ST_SHIFT_RD: ram_req.raddr = ptr_q + ADDR_W'(1);
			ST_SHIFT_WR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = ram_rdata;
			end
			ST_READ_RD:  ram_req.raddr = index_q;
			ST_READ_CMP: ram_req.raddr = index_q;
			default:     req_ready = 1'b0;
		endcase
	end

	assign res_valid         = done_q;
	assign res.hit           = hit_q;
	assign res.rejected_full = full_q;
	assign res.entry_value   = ev_q;
	assign res.index_valid   = valid_q;
	assign res.count         = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_q && res_ready) begin
				done_q <= 1'b0;
			end
			// Any return to idle from a working state finishes the transaction.
			if (state_q != ST_IDLE && state_d == ST_IDLE) begin
				done_q <= 1'b1;
			end
			if (accept && state_d == ST_IDLE) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_APPEND && !is_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			// The count drops as soon as the match is found; the shift then
			// runs up to the new count.
			if (state_q == ST_SCAN_CMP && eq && kind_q == KIND_REMOVE) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			value_q <= req.value;
			index_q <= req.index;
			ptr_q   <= '0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
			ev_q    <= '0;
			valid_q <= 1'b0;
		end
		unique case (state_q)
			ST_SCAN_CMP: begin
				if (eq) begin
					hit_q <= 1'b1;
				end else if (more) begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
			end
			ST_APPEND:   full_q <= is_full;
			ST_SHIFT_WR: ptr_q  <= ptr_q + ADDR_W'(1);
			ST_READ_CMP: begin
				ev_q    <= ram_rdata;
				valid_q <= 1'b1;
				hit_q   <= eq;
			end
			default: begin
			end
		endcase
	end

	`ISS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`ISS_ASSERT_NEXT(a_accept_busy, accept, !req_ready, "accepted while busy")
	`ISS_ASSERT_IMP(a_write_range, ram_req.we, {1'b0, ram_req.waddr} <= count_q,
		"write beyond packed entries")
	`ISS_ASSERT_IMP(a_result_idle, res_valid, state_q == ST_IDLE, "result while working")

endmodule

// ----- hdl/integer_set_store.sv -----
// ----------------------------------------------------------------------------
// integer_set_store
// Set of distinct signed 32-bit integers packed in a RAM, with add, remove,
// contains and read-at-index requests and one result for each request.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   kind, value, index
//  rsp      out  hit, rejected_full, entry_value, index_valid, count
//
//  A request scans the entries in turn, a read then a compare each; add appends
//  on a miss, and remove moves each entry above the match down with a read and
//  a write, then closes the shift; a read in range reads and keeps the entry,
//  and a read past the count needs no RAM access. The result waits in the done
//  register, then in the output register behind rsp.valid, and the next request
//  can already be taken. The single RAM read port and the one shared compare
//  set the pace. Reset clears control state; entries are written before read.
//  The result sits in an output register, so a new request is taken while the
//  previous result waits on rsp.ready.
// ----------------------------------------------------------------------------
module integer_set_store (
	input logic         clk,
	input logic         arst_n,
	iss_req_if.sink     req,
	iss_rsp_if.source   rsp
);
	import iss_pkg::*;

	logic              res_valid;
	logic              res_ready;
	rsp_t              res;
	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req.data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	iss_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
